@@ src/asm_pkg.sv @@
package asm_pkg;

  // word capacity and derived widths
  localparam int MAX_WORD = 16;
  localparam int CNT_W    = $clog2(MAX_WORD + 1);

  // fixed field widths
  localparam int ACTION_W = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int SPAN_W   = 16;
  localparam int LEFT_W   = 5;
  localparam int OUT_W    = STATUS_W + SPAN_W + LEFT_W + 1;
  localparam int TDATA_W  = ((OUT_W + 7) / 8) * 8;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [BYTE_W-1:0] SPACE_BYTE = 8'h20;
  localparam logic [SPAN_W-1:0] SPAN_MAX   = '1;

  typedef enum logic [ACTION_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_START  = 2'd2,
    ACT_TEXT   = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_SEARCH = 2'd0,
    ST_FOUND  = 2'd1,
    ST_IDLE   = 2'd2
  } status_t;

  // classified item handed from front to back
  typedef struct packed {
    action_t           action;
    logic [BYTE_W-1:0] data;
    logic              is_zero;
    logic              is_space;
  } item_t;

  // one result item
  typedef struct packed {
    status_t           status;
    logic [SPAN_W-1:0] span;
    logic [LEFT_W-1:0] letters_left;
    logic              rejected;
  } result_t;

endpackage

@@ src/anagram_span_matcher.sv @@
// anagram span matcher: searches text for a span that uses up a loaded word
// as a multiset of bytes.
// input channel s_axis: tuser carries the action (clear word, append word
// byte, start attempt, text byte), tdata carries the byte. output channel
// m_axis: exactly one result item per input item, in order, holding the
// attempt status, the span consumed so far, the letters left and a flag
// for a refused word byte.
// a front stage decodes each item into a two-entry queue; the back stage
// compares the byte against all word slots at once and updates the state
// in the same cycle as it loads the result register.
// throughput: one item per cycle, sustained while m_axis_tready stays high.
// an accepted item is written into the queue; its result is loaded into the
// result register when the item is taken from the head of the queue.
// reset clears the word and leaves no attempt active (status failed/idle);
// it takes effect at once, with no clearing pass.
// when m_axis_tready is low a waiting result holds, the back stage
// stops, and the queue fills; s_axis_tready drops once two items wait.
module anagram_span_matcher (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // byte_req[7:0]
  input  logic [asm_pkg::BYTE_W-1:0]   s_axis_tdata,
  // action[1:0]
  input  logic [asm_pkg::ACTION_W-1:0] s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status[1:0], span[17:2], letters_left[22:18], rejected[23]
  output logic [asm_pkg::TDATA_W-1:0]  m_axis_tdata
);

  logic             item_valid;
  logic             item_ready;
  asm_pkg::item_t   item;
  asm_pkg::result_t res;

  asm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_axis_tvalid),
    .req_ready  (s_axis_tready),
    .req_action (s_axis_tuser),
    .req_byte   (s_axis_tdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item)
  );

  asm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // pack the result, first field in the low bits
  assign m_axis_tdata = asm_pkg::TDATA_W'({res.rejected, res.letters_left, res.span,
                                           res.status});

endmodule

@@ src/asm_front.sv @@
module asm_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [asm_pkg::ACTION_W-1:0] req_action,
  input  logic [asm_pkg::BYTE_W-1:0]   req_byte,
  output logic                         item_valid,
  input  logic                         item_ready,
  output asm_pkg::item_t               item
);

  asm_pkg::item_t              q [asm_pkg::QDEPTH];
  logic [asm_pkg::QPTR_W-1:0]  wr_ptr;
  logic [asm_pkg::QPTR_W-1:0]  rd_ptr;
  logic [asm_pkg::QCNT_W-1:0]  count;
  asm_pkg::item_t              classified;
  logic                        push;
  logic                        pop;

  // classify the incoming item
  always_comb begin
    classified.action   = asm_pkg::action_t'(req_action);
    classified.data     = req_byte;
    classified.is_zero  = (req_byte == '0);
    classified.is_space = (req_byte == asm_pkg::SPACE_BYTE);
  end

  // queue handshake
  assign req_ready  = (count != asm_pkg::QCNT_W'(asm_pkg::QDEPTH));
  assign item_valid = (count != '0);
  assign item       = q[rd_ptr];
  assign push       = req_valid && req_ready;
  assign pop        = item_valid && item_ready;

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= classified;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == asm_pkg::QPTR_W'(asm_pkg::QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == asm_pkg::QPTR_W'(asm_pkg::QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/asm_back.sv @@
module asm_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  asm_pkg::item_t   item,
  output logic             res_valid,
  input  logic             res_ready,
  output asm_pkg::result_t res
);

  logic [asm_pkg::BYTE_W-1:0] slot_byte      [asm_pkg::MAX_WORD];
  logic [asm_pkg::CNT_W-1:0]  slot_total     [asm_pkg::MAX_WORD];
  logic [asm_pkg::CNT_W-1:0]  slot_remaining [asm_pkg::MAX_WORD];
  logic [asm_pkg::CNT_W-1:0]  slots_used;
  logic [asm_pkg::CNT_W-1:0]  word_length;
  logic [asm_pkg::CNT_W-1:0]  unmatched_count;
  asm_pkg::status_t           attempt_status;
  logic [asm_pkg::SPAN_W-1:0] span_count;

  logic [asm_pkg::BYTE_W-1:0] slot_byte_next      [asm_pkg::MAX_WORD];
  logic [asm_pkg::CNT_W-1:0]  slot_total_next     [asm_pkg::MAX_WORD];
  logic [asm_pkg::CNT_W-1:0]  slot_remaining_next [asm_pkg::MAX_WORD];
  logic [asm_pkg::CNT_W-1:0]  slots_used_next;
  logic [asm_pkg::CNT_W-1:0]  word_length_next;
  logic [asm_pkg::CNT_W-1:0]  unmatched_count_next;
  asm_pkg::status_t           attempt_status_next;
  logic [asm_pkg::SPAN_W-1:0] span_count_next;

  logic [asm_pkg::MAX_WORD-1:0] match_vec;
  logic [asm_pkg::MAX_WORD-1:0] hit_vec;
  logic [asm_pkg::CNT_W-1:0]    unmatched_dec;
  logic [asm_pkg::SPAN_W-1:0]   span_bumped;
  logic                         word_full;
  logic                         rej;
  logic                         fire;

  assign item_ready = !res_valid || res_ready;
  assign fire       = item_valid && item_ready;

  // parallel compare against every slot in use
  always_comb begin
    for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
      match_vec[i] = (asm_pkg::CNT_W'(i) < slots_used) && (slot_byte[i] == item.data);
      hit_vec[i]   = match_vec[i] && (slot_remaining[i] != '0);
    end
  end

  assign word_full     = (word_length >= asm_pkg::CNT_W'(asm_pkg::MAX_WORD));
  assign unmatched_dec = (unmatched_count != '0) ? unmatched_count - 1'b1 : unmatched_count;
  assign span_bumped   = (span_count != asm_pkg::SPAN_MAX) ? span_count + 1'b1 : span_count;

  // next state for the item at the head of the queue
  always_comb begin
    slot_byte_next       = slot_byte;
    slot_total_next      = slot_total;
    slot_remaining_next  = slot_remaining;
    slots_used_next      = slots_used;
    word_length_next     = word_length;
    unmatched_count_next = unmatched_count;
    attempt_status_next  = attempt_status;
    span_count_next      = span_count;
    rej                  = 1'b0;
    case (item.action)
      asm_pkg::ACT_CLEAR: begin
        for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
          slot_total_next[i]     = '0;
          slot_remaining_next[i] = '0;
        end
        slots_used_next      = '0;
        word_length_next     = '0;
        unmatched_count_next = '0;
        attempt_status_next  = asm_pkg::ST_IDLE;
        span_count_next      = '0;
      end
      asm_pkg::ACT_APPEND: begin
        if (item.is_zero || word_full) begin
          rej = 1'b1;
        end else if (|match_vec) begin
          // another copy of a byte already held
          for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
            if (match_vec[i]) begin
              slot_total_next[i] = slot_total[i] + 1'b1;
            end
          end
          word_length_next = word_length + 1'b1;
        end else if (slots_used < asm_pkg::CNT_W'(asm_pkg::MAX_WORD)) begin
          // open a new slot, nothing remaining in the running attempt
          for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
            if (asm_pkg::CNT_W'(i) == slots_used) begin
              slot_byte_next[i]      = item.data;
              slot_total_next[i]     = asm_pkg::CNT_W'(1);
              slot_remaining_next[i] = '0;
            end
          end
          slots_used_next  = slots_used + 1'b1;
          word_length_next = word_length + 1'b1;
        end else begin
          rej = 1'b1;
        end
      end
      asm_pkg::ACT_START: begin
        slot_remaining_next  = slot_total;
        unmatched_count_next = word_length;
        span_count_next      = '0;
        attempt_status_next  = asm_pkg::ST_SEARCH;
      end
      asm_pkg::ACT_TEXT: begin
        if (attempt_status == asm_pkg::ST_SEARCH) begin
          if (item.is_zero) begin
            attempt_status_next = asm_pkg::ST_IDLE;
          end else if (|hit_vec) begin
            for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
              if (hit_vec[i]) begin
                slot_remaining_next[i] = slot_remaining[i] - 1'b1;
              end
            end
            unmatched_count_next = unmatched_dec;
            span_count_next      = span_bumped;
            if (unmatched_dec == '0) begin
              attempt_status_next = asm_pkg::ST_FOUND;
            end
          end else begin
            span_count_next = span_bumped;
            if (!item.is_space) begin
              attempt_status_next = asm_pkg::ST_IDLE;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // word bytes, written only when a slot opens
  always_ff @(posedge clk) begin
    if (fire) begin
      slot_byte <= slot_byte_next;
    end
  end

  // word and attempt state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
        slot_total[i]     <= '0;
        slot_remaining[i] <= '0;
      end
      slots_used      <= '0;
      word_length     <= '0;
      unmatched_count <= '0;
      attempt_status  <= asm_pkg::ST_IDLE;
      span_count      <= '0;
    end else if (fire) begin
      slot_total      <= slot_total_next;
      slot_remaining  <= slot_remaining_next;
      slots_used      <= slots_used_next;
      word_length     <= word_length_next;
      unmatched_count <= unmatched_count_next;
      attempt_status  <= attempt_status_next;
      span_count      <= span_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res.status       <= attempt_status_next;
      res.span         <= span_count_next;
      res.letters_left <= asm_pkg::LEFT_W'(unmatched_count_next);
      res.rejected     <= rej;
    end
  end

`ifndef SYNTHESIS
  a_unmatched_in_word: assert property (@(posedge clk) disable iff (rst)
    unmatched_count <= word_length)
    else $error("more letters unmatched than the word holds");

  a_word_capacity: assert property (@(posedge clk) disable iff (rst)
    word_length <= asm_pkg::CNT_W'(asm_pkg::MAX_WORD))
    else $error("word length beyond capacity");

  a_slots_in_word: assert property (@(posedge clk) disable iff (rst)
    slots_used <= word_length)
    else $error("more slots than word bytes");

  a_found_empty: assert property (@(posedge clk) disable iff (rst)
    attempt_status == asm_pkg::ST_FOUND |-> unmatched_count == '0)
    else $error("found with letters still unmatched");
`endif

endmodule

@@ test/asm_result_checker.sv @@
// watches both stream channels of the anagram span matcher, predicts the
// result of every accepted item and compares each result field by field
module asm_result_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [asm_pkg::BYTE_W-1:0]   s_axis_tdata,
  input  logic [asm_pkg::ACTION_W-1:0] s_axis_tuser,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [asm_pkg::TDATA_W-1:0]  m_axis_tdata,
  output int                           errors,
  output int                           pending,
  output int                           results,
  output int                           live_items,
  output int                           found,
  output int                           refused,
  output int                           peak_span
);
  timeunit 1ns;
  timeprecision 1ps;

  // predicted word multiset and attempt state
  logic [asm_pkg::BYTE_W-1:0] slot_val [asm_pkg::MAX_WORD];
  int                         slot_cnt [asm_pkg::MAX_WORD];
  int                         slot_left[asm_pkg::MAX_WORD];
  int                         n_slots;
  int                         word_len;
  int                         to_match;
  asm_pkg::status_t           att_status;
  logic [asm_pkg::SPAN_W-1:0] span_cnt;

  // results still owed by the block, oldest first
  asm_pkg::result_t expected_q[$];

  // empty word, no attempt
  function automatic void clear_word();
    for (int i = 0; i < asm_pkg::MAX_WORD; i++) begin
      slot_cnt[i]  = 0;
      slot_left[i] = 0;
    end
    n_slots    = 0;
    word_len   = 0;
    to_match   = 0;
    att_status = asm_pkg::ST_IDLE;
    span_cnt   = '0;
  endfunction

  // apply one item to the predicted state and return its result
  function automatic asm_pkg::result_t match_step(asm_pkg::action_t act,
                                                  logic [asm_pkg::BYTE_W-1:0] b);
    asm_pkg::result_t r;
    logic             hit;
    hit        = 1'b0;
    r.rejected = 1'b0;
    case (act)
      asm_pkg::ACT_CLEAR: begin
        clear_word();
      end
      asm_pkg::ACT_APPEND: begin
        if (b == '0 || word_len >= asm_pkg::MAX_WORD) begin
          r.rejected = 1'b1;
        end else begin
          for (int i = 0; i < n_slots; i++) begin
            if (!hit && slot_val[i] == b) begin
              slot_cnt[i]++;
              hit = 1'b1;
            end
          end
          // a new slot joins a running attempt with nothing left to match
          if (!hit) begin
            slot_val[n_slots]  = b;
            slot_cnt[n_slots]  = 1;
            slot_left[n_slots] = 0;
            n_slots++;
          end
          word_len++;
        end
      end
      asm_pkg::ACT_START: begin
        for (int i = 0; i < asm_pkg::MAX_WORD; i++) slot_left[i] = slot_cnt[i];
        to_match   = word_len;
        span_cnt   = '0;
        att_status = asm_pkg::ST_SEARCH;
      end
      default: begin
        if (att_status == asm_pkg::ST_SEARCH) begin
          if (b == '0) begin
            // zero byte ends the text, span untouched
            att_status = asm_pkg::ST_IDLE;
          end else begin
            for (int i = 0; i < n_slots; i++) begin
              if (!hit && slot_val[i] == b && slot_left[i] != 0) begin
                slot_left[i]--;
                hit = 1'b1;
              end
            end
            if (span_cnt != asm_pkg::SPAN_MAX) span_cnt++;
            if (hit) begin
              if (to_match > 0) to_match--;
              if (to_match == 0) att_status = asm_pkg::ST_FOUND;
            end else if (b != asm_pkg::SPACE_BYTE) begin
              att_status = asm_pkg::ST_IDLE;
            end
          end
        end
      end
    endcase
    r.status       = att_status;
    r.span         = span_cnt;
    r.letters_left = to_match[asm_pkg::LEFT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    asm_pkg::result_t want;
    asm_pkg::result_t got;
    asm_pkg::status_t prev;
    if (rst) begin
      clear_word();
      for (int i = 0; i < asm_pkg::MAX_WORD; i++) slot_val[i] = '0;
      expected_q.delete();
      errors     = 0;
      results    = 0;
      live_items = 0;
      found      = 0;
      refused    = 0;
      peak_span  = 0;
    end else begin
      // accepted input item
      if (s_axis_tvalid && s_axis_tready) begin
        prev = att_status;
        want = match_step(asm_pkg::action_t'(s_axis_tuser), s_axis_tdata);
        expected_q.push_back(want);
        if (asm_pkg::action_t'(s_axis_tuser) != asm_pkg::ACT_TEXT ||
            prev == asm_pkg::ST_SEARCH) live_items++;
        if (prev != asm_pkg::ST_FOUND && want.status == asm_pkg::ST_FOUND) found++;
        if (want.rejected) refused++;
        if (int'(want.span) > peak_span) peak_span = int'(want.span);
      end
      // accepted result item
      if (m_axis_tvalid && m_axis_tready) begin
        got.status       = asm_pkg::status_t'(m_axis_tdata[1:0]);
        got.span         = m_axis_tdata[17:2];
        got.letters_left = m_axis_tdata[22:18];
        got.rejected     = m_axis_tdata[23];
        results++;
        if (expected_q.size() == 0) begin
          $error("result item with nothing expected: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
          end
          if (got.span !== want.span) begin
            $error("span mismatch: expected %0d, actual %0d", want.span, got.span);
            errors++;
          end
          if (got.letters_left !== want.letters_left) begin
            $error("letters_left mismatch: expected %0d, actual %0d",
                   want.letters_left, got.letters_left);
            errors++;
          end
          if (got.rejected !== want.rejected) begin
            $error("rejected mismatch: expected %0d, actual %0d",
                   want.rejected, got.rejected);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

@@ test/tb_anagram_span_matcher.sv @@
module tb_anagram_span_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int RANDOM_ITEMS = 1800;

  logic                         clk;
  logic                         rst = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [asm_pkg::BYTE_W-1:0]   s_axis_tdata = '0;
  logic [asm_pkg::ACTION_W-1:0] s_axis_tuser = asm_pkg::ACT_CLEAR;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [asm_pkg::TDATA_W-1:0]  m_axis_tdata;

  int fail_count;
  int pending_results;
  int checked_results;
  int live_items;
  int found_count;
  int refused_count;
  int peak_span;
  int sent_count = 0;

  // no idling on either side while set
  bit steady = 1'b0;

  // word as loaded so far, used to shape well-formed text
  logic [asm_pkg::BYTE_W-1:0] word_buf[asm_pkg::MAX_WORD];
  int                         word_fill = 0;

  anagram_span_matcher dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  asm_result_checker chk (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .errors       (fail_count),
    .pending      (pending_results),
    .results      (checked_results),
    .live_items   (live_items),
    .found        (found_count),
    .refused      (refused_count),
    .peak_span    (peak_span)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // result side stalls at random
  always @(negedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 30);
  end

  // run limit
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // send one item; starts and ends at a falling edge
  task automatic send_item(input asm_pkg::action_t act,
                           input logic [asm_pkg::BYTE_W-1:0] b);
    while (!steady && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_count++;
    // track the loaded word
    if (act == asm_pkg::ACT_CLEAR) begin
      word_fill = 0;
    end else if (act == asm_pkg::ACT_APPEND && b != '0 && word_fill < asm_pkg::MAX_WORD) begin
      word_buf[word_fill] = b;
      word_fill++;
    end
  endtask

  initial begin
    int                         seq;
    int                         n;
    int                         k;
    int                         pick;
    int                         pool_n;
    int                         order_n;
    bit                         cut;
    logic [asm_pkg::BYTE_W-1:0] pool[5];
    logic [asm_pkg::BYTE_W-1:0] order[asm_pkg::MAX_WORD];
    logic [asm_pkg::BYTE_W-1:0] tmp;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: text with no attempt, empty word, zero byte, refused append
    send_item(asm_pkg::ACT_TEXT, 8'h61);
    send_item(asm_pkg::ACT_START, 8'hFF);
    send_item(asm_pkg::ACT_TEXT, asm_pkg::SPACE_BYTE);
    send_item(asm_pkg::ACT_TEXT, 8'h61);
    send_item(asm_pkg::ACT_START, 8'h00);
    send_item(asm_pkg::ACT_TEXT, 8'h00);
    send_item(asm_pkg::ACT_APPEND, 8'h00);
    // word with a repeated letter and the byte extremes
    send_item(asm_pkg::ACT_APPEND, 8'h61);
    send_item(asm_pkg::ACT_APPEND, 8'hFF);
    send_item(asm_pkg::ACT_APPEND, 8'h61);
    send_item(asm_pkg::ACT_APPEND, 8'h80);
    send_item(asm_pkg::ACT_START, 8'h00);
    send_item(asm_pkg::ACT_TEXT, 8'h61);
    send_item(asm_pkg::ACT_TEXT, asm_pkg::SPACE_BYTE);
    // append during an attempt, then its byte fails the attempt
    send_item(asm_pkg::ACT_APPEND, 8'h01);
    send_item(asm_pkg::ACT_TEXT, 8'h01);
    // full match with the grown word, then text after found
    send_item(asm_pkg::ACT_START, 8'h00);
    send_item(asm_pkg::ACT_TEXT, 8'h80);
    send_item(asm_pkg::ACT_TEXT, 8'hFF);
    send_item(asm_pkg::ACT_TEXT, 8'h01);
    send_item(asm_pkg::ACT_TEXT, 8'h61);
    send_item(asm_pkg::ACT_TEXT, 8'h61);
    send_item(asm_pkg::ACT_TEXT, 8'h61);
    send_item(asm_pkg::ACT_CLEAR, 8'hFF);
    send_item(asm_pkg::ACT_TEXT, asm_pkg::SPACE_BYTE);

    // random: mostly load, start and shuffled text, some noise
    seq = 0;
    while (sent_count < RANDOM_ITEMS) begin
      steady = (seq >= 40 && seq < 70);
      if ($urandom_range(0, 99) < 12) begin
        n = $urandom_range(1, 6);
        repeat (n) send_item(asm_pkg::action_t'($urandom_range(0, 3)),
                             asm_pkg::BYTE_W'($urandom_range(0, 255)));
      end else begin
        if ($urandom_range(0, 99) < 70) begin
          send_item(asm_pkg::ACT_CLEAR, asm_pkg::BYTE_W'($urandom_range(0, 255)));
        end
        pool_n = $urandom_range(1, 5);
        for (int j = 0; j < pool_n; j++) pool[j] = asm_pkg::BYTE_W'($urandom_range(1, 255));
        k = ($urandom_range(0, 99) < 12) ? $urandom_range(14, 18) : $urandom_range(1, 6);
        for (int j = 0; j < k; j++) begin
          tmp = ($urandom_range(0, 99) < 4) ? 8'h00 : pool[$urandom_range(0, pool_n - 1)];
          send_item(asm_pkg::ACT_APPEND, tmp);
        end
        send_item(asm_pkg::ACT_START, asm_pkg::BYTE_W'($urandom_range(0, 255)));
        // shuffle the word into text order
        order_n = word_fill;
        for (int j = 0; j < order_n; j++) order[j] = word_buf[j];
        for (int j = order_n - 1; j > 0; j--) begin
          pick = $urandom_range(0, j);
          tmp = order[j];
          order[j] = order[pick];
          order[pick] = tmp;
        end
        cut = (order_n > 0 && $urandom_range(0, 99) < 10);
        if (cut) order_n--;
        for (int j = 0; j < order_n; j++) begin
          if ($urandom_range(0, 99) < 15) send_item(asm_pkg::ACT_TEXT, asm_pkg::SPACE_BYTE);
          if ($urandom_range(0, 99) < 3) begin
            send_item(asm_pkg::ACT_TEXT, asm_pkg::BYTE_W'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 99) < 2) begin
            send_item(asm_pkg::ACT_APPEND, pool[$urandom_range(0, pool_n - 1)]);
          end
          send_item(asm_pkg::ACT_TEXT, order[j]);
        end
        // broken ending or trailing text
        if (cut || $urandom_range(0, 99) < 25) begin
          n = $urandom_range(1, 2);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0: tmp = 8'h00;
              1: tmp = asm_pkg::SPACE_BYTE;
              default: tmp = asm_pkg::BYTE_W'($urandom_range(0, 255));
            endcase
            send_item(asm_pkg::ACT_TEXT, tmp);
          end
        end
      end
      seq++;
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("checked %0d result items, %0d attempts found, %0d refused appends",
             checked_results, found_count, refused_count);
    $display("%0d items changed state, peak span %0d", live_items, peak_span);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/asm_pkg.sv
src/asm_front.sv
src/asm_back.sv
src/anagram_span_matcher.sv
test/asm_result_checker.sv
test/tb_anagram_span_matcher.sv
